// File: hw/rtl/bspll_pkg.sv
// Shared types, field widths and helpers for the BSP point leaf locator.
// Depends on nothing; imported by bspll_ram users and the top level.
package bspll_pkg;

   localparam int unsigned NodeCountDefault  = 1024;
   localparam int unsigned PlaneCountDefault = 1024;
   localparam int unsigned LeafCountDefault  = 1024;
   localparam int unsigned MaxStepsDefault   = 64;

   localparam int unsigned IndexWidth = 10;
   localparam int unsigned ChildWidth = 11;
   localparam int unsigned VecWidth   = 24;
   localparam int unsigned NormWidth  = 16;
   localparam int unsigned ProdWidth  = NormWidth + VecWidth;
   localparam int unsigned DistWidth  = ProdWidth + 3;

   localparam int unsigned NodeWidth  = IndexWidth + 2 * ChildWidth;
   localparam int unsigned PlaneWidth = 3 * NormWidth + VecWidth;

   typedef enum logic [1:0] {
      OP_WRITE_NODE  = 2'd0,
      OP_WRITE_PLANE = 2'd1,
      OP_LOCATE      = 2'd2,
      OP_NONE        = 2'd3
   } opcode_type;

   typedef struct packed {
      logic signed [ChildWidth-1:0] back_child;
      logic signed [ChildWidth-1:0] front_child;
      logic [IndexWidth-1:0]        plane_ref;
   } node_type;

   typedef struct packed {
      logic signed [VecWidth-1:0]  offset;
      logic signed [NormWidth-1:0] norm_z;
      logic signed [NormWidth-1:0] norm_y;
      logic signed [NormWidth-1:0] norm_x;
   } plane_type;

   // Clamps a normal component to the signed 16-bit range.
   function automatic logic signed [NormWidth-1:0] sat_norm(input logic signed [VecWidth-1:0] v);
      logic signed [NormWidth-1:0] r;
      if (v > 24'sh007FFF) begin
         r = 16'sh7FFF;
      end else if (v < -24'sh008000) begin
         r = -16'sh8000;
      end else begin
         r = v[NormWidth-1:0];
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/bspll_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Stand-alone; instantiated for the node and plane tables.
module bspll_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/bsp_point_leaf_locator.sv
// Top level of the BSP point leaf locator: load and query control, walk sequencer.
// Depends on bspll_pkg and bspll_ram (node table and plane table).
//
//   channel  dir  tdata                                   tuser
//   req_     in   index,plane_ref,front,back,x,y,z,offset  opcode
//   rsp_     out  leaf_number                              walk_overrun
//
// A load word is written as it is accepted. A query passes S_NODE, S_PLANE and
// S_EVAL per node visited (node read, plane read, registered products), then S_DONE.
// One query walks at a time; loads are taken while a result waits on the output.
// Reset clears control state only; both tables are undefined until loaded.
module bsp_point_leaf_locator
   import bspll_pkg::*;
#(
   parameter int unsigned NODE_COUNT  = NodeCountDefault,
   parameter int unsigned PLANE_COUNT = PlaneCountDefault,
   parameter int unsigned LEAF_COUNT  = LeafCountDefault,
   parameter int unsigned MAX_STEPS   = MaxStepsDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // entry_index[9:0], plane_ref[19:10], front_child[30:20], back_child[41:31],
   // vec_x[65:42], vec_y[89:66], vec_z[113:90], plane_offset[137:114], zero fill
   input  logic [143:0] req_tdata,
   // opcode[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // leaf_number[9:0], zero fill
   output logic [15:0]  rsp_tdata,
   // walk_overrun[0]
   output logic [0:0]   rsp_tuser
);

   localparam int unsigned NodeAw  = NODE_COUNT > 1 ? $clog2(NODE_COUNT) : 1;
   localparam int unsigned PlaneAw = PLANE_COUNT > 1 ? $clog2(PLANE_COUNT) : 1;
   localparam int unsigned StepW   = $clog2(MAX_STEPS + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_NODE,
      S_PLANE,
      S_EVAL,
      S_DONE
   } state_type;

   // Input fields.
   opcode_type                  req_op;
   logic [IndexWidth-1:0]       req_entry_index;
   logic [IndexWidth-1:0]       req_plane_ref;
   logic signed [ChildWidth-1:0] req_front_child;
   logic signed [ChildWidth-1:0] req_back_child;
   logic signed [VecWidth-1:0]  req_vec_x;
   logic signed [VecWidth-1:0]  req_vec_y;
   logic signed [VecWidth-1:0]  req_vec_z;
   logic signed [VecWidth-1:0]  req_plane_offset;

   assign req_op           = opcode_type'(req_tuser);
   assign req_entry_index  = req_tdata[9:0];
   assign req_plane_ref    = req_tdata[19:10];
   assign req_front_child  = req_tdata[30:20];
   assign req_back_child   = req_tdata[41:31];
   assign req_vec_x        = req_tdata[65:42];
   assign req_vec_y        = req_tdata[89:66];
   assign req_vec_z        = req_tdata[113:90];
   assign req_plane_offset = req_tdata[137:114];

   // Registers.
   state_type                    state_ff, state_in;
   logic signed [VecWidth-1:0]   px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic [StepW-1:0]             steps_ff, steps_in;
   logic                         node_oob_ff, node_oob_in;
   logic                         plane_oob_ff, plane_oob_in;
   logic signed [ChildWidth-1:0] front_ff, front_in, back_ff, back_in;
   logic signed [ProdWidth-1:0]  prod_x_ff, prod_x_in, prod_y_ff, prod_y_in;
   logic signed [ProdWidth-1:0]  prod_z_ff, prod_z_in;
   logic signed [VecWidth-1:0]   dofs_ff, dofs_in;
   logic [IndexWidth-1:0]        res_leaf_ff, res_leaf_in;
   logic                         res_over_ff, res_over_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [IndexWidth-1:0]        rsp_leaf_ff, rsp_leaf_in;
   logic                         rsp_over_ff, rsp_over_in;

   // Memory ports.
   logic                         node_we, node_re;
   logic [NodeAw-1:0]            node_waddr, node_raddr;
   node_type                     node_wdata, node_rdata, node_cur;
   logic                         plane_we, plane_re;
   logic [PlaneAw-1:0]           plane_waddr, plane_raddr;
   plane_type                    plane_wdata, plane_rdata, plane_cur;

   // Evaluation signals.
   logic                         req_accept;
   logic signed [DistWidth-1:0]  side_dist;
   logic signed [DistWidth-1:0]  dofs_ext;
   logic signed [ChildWidth-1:0] next_idx;
   logic [StepW-1:0]             steps_next;
   logic [IndexWidth-1:0]        leaf_raw;
   logic                         rsp_free;

   bspll_ram #(
      .WIDTH(NodeWidth),
      .DEPTH(NODE_COUNT)
   ) u_node_ram (
      .clock  (clock),
      .wr_en  (node_we),
      .wr_addr(node_waddr),
      .wr_data(node_wdata),
      .rd_en  (node_re),
      .rd_addr(node_raddr),
      .rd_data(node_rdata)
   );

   bspll_ram #(
      .WIDTH(PlaneWidth),
      .DEPTH(PLANE_COUNT)
   ) u_plane_ram (
      .clock  (clock),
      .wr_en  (plane_we),
      .wr_addr(plane_waddr),
      .wr_data(plane_wdata),
      .rd_en  (plane_re),
      .rd_addr(plane_raddr),
      .rd_data(plane_rdata)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // Load writes.
   assign node_we    = req_accept && (req_op == OP_WRITE_NODE)
                       && (32'(req_entry_index) < NODE_COUNT);
   assign node_waddr = NodeAw'(req_entry_index);
   assign node_wdata = '{back_child: req_back_child, front_child: req_front_child,
                         plane_ref: req_plane_ref};

   assign plane_we    = req_accept && (req_op == OP_WRITE_PLANE)
                        && (32'(req_entry_index) < PLANE_COUNT);
   assign plane_waddr = PlaneAw'(req_entry_index);
   assign plane_wdata = '{offset: req_plane_offset, norm_z: sat_norm(req_vec_z),
                          norm_y: sat_norm(req_vec_y), norm_x: sat_norm(req_vec_x)};

   // Out-of-range entries read as all zero.
   assign node_cur  = node_oob_ff ? '0 : node_rdata;
   assign plane_cur = plane_oob_ff ? '0 : plane_rdata;

   assign dofs_ext   = DistWidth'(dofs_ff);
   assign side_dist  = DistWidth'(prod_x_ff) + DistWidth'(prod_y_ff) + DistWidth'(prod_z_ff)
                       - (dofs_ext <<< 14);
   assign next_idx   = (side_dist >= 0) ? front_ff : back_ff;
   assign steps_next = steps_ff + StepW'(1);
   assign leaf_raw   = ~next_idx[IndexWidth-1:0];

   always_comb begin
      state_in     = state_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      pz_in        = pz_ff;
      steps_in     = steps_ff;
      node_oob_in  = node_oob_ff;
      plane_oob_in = plane_oob_ff;
      front_in     = front_ff;
      back_in      = back_ff;
      prod_x_in    = prod_x_ff;
      prod_y_in    = prod_y_ff;
      prod_z_in    = prod_z_ff;
      dofs_in      = dofs_ff;
      res_leaf_in  = res_leaf_ff;
      res_over_in  = res_over_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_leaf_in  = rsp_leaf_ff;
      rsp_over_in  = rsp_over_ff;
      node_re      = 1'b0;
      node_raddr   = '0;
      plane_re     = 1'b0;
      plane_raddr  = PlaneAw'(node_cur.plane_ref);

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept && req_op == OP_LOCATE) begin
               // The walk always starts at node 0.
               px_in       = req_vec_x;
               py_in       = req_vec_y;
               pz_in       = req_vec_z;
               steps_in    = '0;
               node_re     = 1'b1;
               node_raddr  = '0;
               node_oob_in = 1'b0;
               state_in    = S_NODE;
            end
         end
         S_NODE: begin
            front_in     = node_cur.front_child;
            back_in      = node_cur.back_child;
            plane_re     = 1'b1;
            plane_oob_in = 32'(node_cur.plane_ref) >= PLANE_COUNT;
            state_in     = S_PLANE;
         end
         S_PLANE: begin
            prod_x_in = plane_cur.norm_x * px_ff;
            prod_y_in = plane_cur.norm_y * py_ff;
            prod_z_in = plane_cur.norm_z * pz_ff;
            dofs_in   = plane_cur.offset;
            state_in  = S_EVAL;
         end
         S_EVAL: begin
            steps_in = steps_next;
            if (next_idx < 0) begin
               res_over_in = 1'b0;
               res_leaf_in = (32'(leaf_raw) >= LEAF_COUNT) ? IndexWidth'(LEAF_COUNT - 1)
                                                           : leaf_raw;
               state_in    = S_DONE;
            end else if (32'(steps_next) >= MAX_STEPS) begin
               res_over_in = 1'b1;
               res_leaf_in = '0;
               state_in    = S_DONE;
            end else begin
               node_re     = 1'b1;
               node_raddr  = NodeAw'(next_idx[IndexWidth-1:0]);
               node_oob_in = 32'(next_idx[IndexWidth-1:0]) >= NODE_COUNT;
               state_in    = S_NODE;
            end
         end
         S_DONE: begin
            // Hold the result until the output word is free.
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_leaf_in  = res_leaf_ff;
               rsp_over_in  = res_over_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         steps_ff     <= '0;
         node_oob_ff  <= 1'b0;
         plane_oob_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         steps_ff     <= steps_in;
         node_oob_ff  <= node_oob_in;
         plane_oob_ff <= plane_oob_in;
      end
      px_ff       <= px_in;
      py_ff       <= py_in;
      pz_ff       <= pz_in;
      front_ff    <= front_in;
      back_ff     <= back_in;
      prod_x_ff   <= prod_x_in;
      prod_y_ff   <= prod_y_in;
      prod_z_ff   <= prod_z_in;
      dofs_ff     <= dofs_in;
      res_leaf_ff <= res_leaf_in;
      res_over_ff <= res_over_in;
      rsp_leaf_ff <= rsp_leaf_in;
      rsp_over_ff <= rsp_over_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_leaf_ff};
   assign rsp_tuser  = rsp_over_ff;

   // The walk never visits more nodes than the step limit allows.
   a_step_limit: assert property (@(posedge clock) disable iff (reset)
      32'(steps_ff) <= MAX_STEPS)
      else $error("step counter beyond limit");

   // Table writes only happen while no walk is in flight.
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      (node_we || plane_we) |-> (state_ff == S_IDLE))
      else $error("table write during a walk");

   // An overrun result always carries leaf zero.
   a_overrun_leaf: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_over_ff) |-> (rsp_leaf_ff == '0))
      else $error("overrun result with nonzero leaf");

   // A finished walk loads a new result word once the output word is free.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_free) |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("finished walk did not produce a result");

   // Node reads are only issued on a query start or a continuing walk.
   a_node_read: assert property (@(posedge clock) disable iff (reset)
      node_re |=> (state_ff == S_NODE))
      else $error("node read outside the walk");

endmodule

// File: sim/tb.sv
// Self-checking testbench for the BSP point leaf locator: loads trees, walks points through them.
// Depends on bspll_pkg and the bsp_point_leaf_locator RTL; the walk is predicted locally.
`timescale 1ns / 1ps

module tb;
   import bspll_pkg::*;

   localparam int unsigned NodeCount  = NodeCountDefault;
   localparam int unsigned PlaneCount = PlaneCountDefault;
   localparam int unsigned LeafCount  = LeafCountDefault;
   localparam int unsigned MaxSteps   = MaxStepsDefault;
   localparam int          RandomWords = 1500;

   typedef struct {
      opcode_type               op;
      logic [9:0]               entry;
      logic [9:0]               pref;
      logic signed [10:0]       front;
      logic signed [10:0]       back;
      logic signed [23:0]       vx;
      logic signed [23:0]       vy;
      logic signed [23:0]       vz;
      logic signed [23:0]       offs;
   } bsp_word_type;

   typedef struct {
      logic [9:0] leaf;
      logic       overrun;
   } leaf_due_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [143:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [15:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;

   // Copy 0 shadows the tables in queue order for the generator; copy 1 follows accepted words.
   node_type  node_mem  [2][NodeCount];
   plane_type plane_mem [2][PlaneCount];
   bit        node_set  [NodeCount];
   bit        plane_set [PlaneCount];

   bsp_word_type pend_q[$];
   leaf_due_type leaf_due_q[$];
   int        tree_ids[32];

   int unsigned cyc = 0;
   int        gen_count = 0;
   int        taken_count = 0;
   int        rsp_count = 0;
   int        fail_count = 0;
   bit        req_taken = 0;
   int        send_gap = 0;
   int        stall_left = 0;
   int        hold_left = 0;
   bit        hold_done = 0;
   bsp_word_type cur;
   bsp_word_type seen;
   leaf_due_type want;
   bit        seen_rsp;
   logic [9:0] seen_leaf;
   logic      seen_ovr;

   bsp_point_leaf_locator #(
      .NODE_COUNT (NodeCount),
      .PLANE_COUNT(PlaneCount),
      .LEAF_COUNT (LeafCount),
      .MAX_STEPS  (MaxSteps)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic signed [15:0] clamp_norm(input logic signed [23:0] v);
      if (v > 32767) begin
         return 16'sh7FFF;
      end else if (v < -32768) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   // Walks a point through table copy c. On copy 0 the walk stops at the first entry
   // that was never written and names it, so the generator can load it first.
   function automatic void walk_tree(input int c, input logic signed [23:0] px,
                                     input logic signed [23:0] py,
                                     input logic signed [23:0] pz,
                                     output logic [9:0] leaf, output logic overrun,
                                     output int gap_node, output int gap_plane);
      longint    idx;
      longint    nx, ny, nz, d, ax, ay, az, side_val, lf;
      int        steps;
      node_type  nd;
      plane_type pl;
      idx = 0;
      steps = 0;
      gap_node = -1;
      gap_plane = -1;
      leaf = '0;
      overrun = 1'b0;
      ax = px;
      ay = py;
      az = pz;
      while (idx >= 0 && steps < MaxSteps && gap_node < 0 && gap_plane < 0) begin
         nd = '0;
         pl = '0;
         if (idx < NodeCount) begin
            if (c == 0 && !node_set[idx]) gap_node = int'(idx);
            nd = node_mem[c][idx];
         end
         if (gap_node < 0) begin
            if (nd.plane_ref < PlaneCount) begin
               if (c == 0 && !plane_set[nd.plane_ref]) gap_plane = int'(nd.plane_ref);
               pl = plane_mem[c][nd.plane_ref];
            end
            if (gap_plane < 0) begin
               nx = pl.norm_x;
               ny = pl.norm_y;
               nz = pl.norm_z;
               d = pl.offset;
               side_val = nx * ax + ny * ay + nz * az - d * 16384;
               if (side_val >= 0) begin
                  idx = nd.front_child;
               end else begin
                  idx = nd.back_child;
               end
               steps++;
            end
         end
      end
      if (idx >= 0) begin
         overrun = 1'b1;
      end else begin
         lf = -1 - idx;
         if (lf >= LeafCount) lf = LeafCount - 1;
         leaf = lf[9:0];
      end
   endfunction

   function automatic void apply_word(input int c, input bsp_word_type w, output bit has_rsp,
                                      output logic [9:0] leaf, output logic overrun);
      int gn, gp;
      has_rsp = 0;
      leaf = '0;
      overrun = 1'b0;
      case (w.op)
         OP_WRITE_NODE: begin
            if (w.entry < NodeCount) begin
               node_mem[c][w.entry] = {w.back, w.front, w.pref};
               if (c == 0) node_set[w.entry] = 1;
            end
         end
         OP_WRITE_PLANE: begin
            if (w.entry < PlaneCount) begin
               plane_mem[c][w.entry] = {w.offs, clamp_norm(w.vz), clamp_norm(w.vy),
                                        clamp_norm(w.vx)};
               if (c == 0) plane_set[w.entry] = 1;
            end
         end
         OP_LOCATE: begin
            walk_tree(c, w.vx, w.vy, w.vz, leaf, overrun, gn, gp);
            has_rsp = 1;
         end
         default: begin
         end
      endcase
   endfunction

   function automatic logic [143:0] pack_word(input bsp_word_type w);
      return {6'd0, w.offs, w.vz, w.vy, w.vx, w.back, w.front, w.pref, w.entry};
   endfunction

   function automatic bsp_word_type noise_word(input opcode_type op);
      bsp_word_type w;
      w.op = op;
      w.entry = 10'($urandom);
      w.pref = 10'($urandom);
      w.front = 11'($urandom);
      w.back = 11'($urandom);
      w.vx = 24'($urandom);
      w.vy = 24'($urandom);
      w.vz = 24'($urandom);
      w.offs = 24'($urandom);
      return w;
   endfunction

   function automatic void push_word(input bsp_word_type w);
      bit         r;
      logic [9:0] l;
      logic       o;
      apply_word(0, w, r, l, o);
      pend_q.push_back(w);
      if (w.op != OP_NONE) gen_count++;
   endfunction

   function automatic logic signed [10:0] rand_leaf();
      logic [9:0] l;
      l = 10'($urandom);
      return ~{1'b0, l};
   endfunction

   function automatic logic signed [23:0] rand_norm();
      logic signed [15:0] s;
      if ($urandom_range(0, 3) == 0) return 24'($urandom);
      s = 16'($urandom);
      return {{8{s[15]}}, s};
   endfunction

   function automatic logic signed [23:0] rand_vec();
      if ($urandom_range(0, 3) == 0) return 24'(int'($urandom_range(0, 2047)) - 1024);
      return 24'($urandom);
   endfunction

   function automatic void put_node(input logic [9:0] slot, input logic [9:0] pref,
                                    input logic signed [10:0] front,
                                    input logic signed [10:0] back);
      bsp_word_type w;
      w = noise_word(OP_WRITE_NODE);
      w.entry = slot;
      w.pref = pref;
      w.front = front;
      w.back = back;
      push_word(w);
   endfunction

   function automatic void put_plane(input logic [9:0] slot, input logic signed [23:0] x,
                                     input logic signed [23:0] y,
                                     input logic signed [23:0] z,
                                     input logic signed [23:0] offs);
      bsp_word_type w;
      w = noise_word(OP_WRITE_PLANE);
      w.entry = slot;
      w.vx = x;
      w.vy = y;
      w.vz = z;
      w.offs = offs;
      push_word(w);
   endfunction

   // Loads whatever the walk of this point would read before it was written, then queries.
   function automatic void put_query(input logic signed [23:0] x, input logic signed [23:0] y,
                                     input logic signed [23:0] z);
      bsp_word_type w;
      logic [9:0] l;
      logic       o;
      int         gn, gp;
      do begin
         walk_tree(0, x, y, z, l, o, gn, gp);
         if (gn >= 0) begin
            put_node(10'(gn), 10'($urandom), rand_leaf(), rand_leaf());
         end else if (gp >= 0) begin
            put_plane(10'(gp), rand_norm(), rand_norm(), rand_norm(), 24'($urandom));
         end
      end while (gn >= 0 || gp >= 0);
      w = noise_word(OP_LOCATE);
      w.vx = x;
      w.vy = y;
      w.vz = z;
      push_word(w);
   endfunction

   function automatic logic signed [10:0] pick_child(input int k, input int size,
                                                     input bit loops);
      if (k == size - 1 || $urandom_range(0, 2) == 0) return rand_leaf();
      if (loops && $urandom_range(0, 1) == 1) return 11'(tree_ids[$urandom_range(0, k)]);
      return 11'(tree_ids[$urandom_range(k + 1, size - 1)]);
   endfunction

   // Builds a tree rooted at node 0; with loops set, children may point back up and
   // some walks then run into the step limit.
   function automatic void grow_tree(input int size, input bit loops);
      logic [9:0] pref;
      tree_ids[0] = 0;
      for (int k = 1; k < size; k++) tree_ids[k] = int'($urandom_range(1, NodeCount - 1));
      for (int k = size - 1; k >= 0; k--) begin
         pref = 10'($urandom);
         put_plane(pref, rand_norm(), rand_norm(), rand_norm(), 24'($urandom));
         put_node(10'(tree_ids[k]), pref, pick_child(k, size, loops),
                  pick_child(k, size, loops));
      end
   endfunction

   function automatic int pick_gap();
      int r;
      // A quarter of the time neither side idles at all.
      if (cyc[9:8] == 2'b00) return 0;
      r = int'($urandom_range(0, 99));
      if (r < 45) return 0;
      if (r < 85) return int'($urandom_range(1, 3));
      if (r < 97) return int'($urandom_range(4, 12));
      return int'($urandom_range(20, 40));
   endfunction

   task automatic report_miss(input string what, input int exp_val, input int got_val);
      $display("ERROR: %s: expected %0d, got %0d", what, exp_val, got_val);
      fail_count++;
   endtask

   always @(posedge clock) begin
      cyc++;
   end

   // Request side: each accepted load word updates the predicted tables; each query queues its result.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         seen.op = opcode_type'(req_tuser);
         seen.entry = req_tdata[9:0];
         seen.pref = req_tdata[19:10];
         seen.front = req_tdata[30:20];
         seen.back = req_tdata[41:31];
         seen.vx = req_tdata[65:42];
         seen.vy = req_tdata[89:66];
         seen.vz = req_tdata[113:90];
         seen.offs = req_tdata[137:114];
         apply_word(1, seen, seen_rsp, seen_leaf, seen_ovr);
         if (seen_rsp) leaf_due_q.push_back('{leaf: seen_leaf, overrun: seen_ovr});
         req_taken = 1;
         taken_count++;
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_taken) begin
            req_taken = 0;
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pend_q.size() > 0) begin
               cur = pend_q.pop_front();
               req_tdata <= pack_word(cur);
               req_tuser <= cur.op;
               req_tvalid <= 1'b1;
               send_gap = pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result side: one long hold-off lets the block back up into its input.
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && rsp_count >= 40) begin
            hold_done = 1;
            hold_left = 400;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_count++;
         if (leaf_due_q.size() == 0) begin
            report_miss("result word with none pending", -1, int'(rsp_tdata[9:0]));
         end else begin
            want = leaf_due_q.pop_front();
            if (rsp_tuser[0] !== want.overrun)
               report_miss("walk_overrun", int'(want.overrun), int'(rsp_tuser[0]));
            if (rsp_tdata[9:0] !== want.leaf)
               report_miss("leaf_number", int'(want.leaf), int'(rsp_tdata[9:0]));
         end
      end
   end

   initial begin
      int r;
      int total;
      // One x-axis plane at the root: a point on the plane goes to the front child.
      put_plane(10'd0, 24'sd16384, 24'sd0, 24'sd0, 24'sd0);
      put_node(10'd0, 10'd0, 11'sh7FF, 11'sh400);
      put_query(24'sd0, 24'sd0, 24'sd0);
      put_query(-24'sd1, 24'sh7FFFFF, 24'sh800000);
      put_query(24'sh7FFFFF, 24'sh800000, 24'sh000000);
      put_query(24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF);
      // Normals beyond 16 bits clamp in both directions; offsets at both extremes.
      put_plane(10'd1023, 24'sh7FFFFF, 24'sh800000, 24'sh007FFF, 24'sh7FFFFF);
      put_plane(10'd1, 24'shFF8000, 24'sh008000, 24'sh000000, 24'sh800000);
      put_node(10'd0, 10'd1023, 11'sd1023, 11'sh7FF);
      put_node(10'd1023, 10'd1, 11'sh400, 11'sh7FE);
      put_query(24'sd0, 24'sd0, 24'sd0);
      put_query(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF);
      put_query(24'sh800000, 24'sh7FFFFF, 24'sh800000);
      put_query(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
      // A root that points at itself never reaches a leaf.
      put_node(10'd0, 10'd0, 11'sd0, 11'sd0);
      put_query(24'sh7FFFFF, 24'sd5, 24'sh800000);
      put_query(-24'sd7, 24'sd0, 24'sd0);
      push_word(noise_word(OP_NONE));
      put_query(24'sd1, 24'sd0, 24'sd0);

      while (gen_count < 20 + RandomWords) begin
         r = int'($urandom_range(0, 99));
         if (r < 60) begin
            if ($urandom_range(0, 9) == 0) begin
               grow_tree(int'($urandom_range(8, 24)), $urandom_range(0, 5) == 0);
            end else begin
               grow_tree(int'($urandom_range(1, 8)), $urandom_range(0, 5) == 0);
            end
            repeat ($urandom_range(4, 16)) put_query(rand_vec(), rand_vec(), rand_vec());
         end else if (r < 75) begin
            repeat ($urandom_range(1, 6)) put_query(rand_vec(), rand_vec(), rand_vec());
         end else if (r < 85) begin
            push_word(noise_word(OP_WRITE_NODE));
         end else if (r < 95) begin
            push_word(noise_word(OP_WRITE_PLANE));
         end else begin
            push_word(noise_word(OP_NONE));
         end
      end
      total = pend_q.size();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      wait (taken_count == total);
      wait (leaf_due_q.size() == 0);
      repeat (250) @(posedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #30000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
